@@ rtl/rmv_pkg.sv @@
package rmv_pkg;

  localparam int SAMPLE_W   = 32;
  localparam int COUNT_W    = 32;
  localparam int THR_W      = 16;
  localparam int SUM_W      = 64;
  localparam int OPA_W      = 64;
  localparam int OPB_W      = 33;
  localparam int RES_W      = OPA_W + OPB_W;
  localparam int CNT_W      = 7;
  localparam int MUL_STEPS  = OPB_W;
  localparam int DIV_STEPS  = OPA_W;
  localparam int SQRT_STEPS = OPA_W / 2;

  localparam logic [1:0] ACT_CLEAR = 2'd0;
  localparam logic [1:0] ACT_ADD   = 2'd1;
  localparam logic [1:0] ACT_CHECK = 2'd2;

  typedef enum logic [1:0] {
    REG_REFERENCE_MEAN  = 2'd0,
    REG_Z_THRESHOLD     = 2'd1,
    REG_SIGMA_THRESHOLD = 2'd2,
    REG_MIN_SAMPLES     = 2'd3
  } cfg_reg_t;

  typedef enum logic [1:0] {
    OP_MUL  = 2'd0,
    OP_DIV  = 2'd1,
    OP_SQRT = 2'd2
  } alu_op_t;

  typedef struct packed {
    logic    start;
    alu_op_t op;
  } alu_cmd_t;

  typedef struct packed {
    logic busy;
    logic done;
  } alu_stat_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_UPD,
    ST_Q,
    ST_P,
    ST_SVAR,
    ST_PVAR,
    ST_SQRT,
    ST_DD,
    ST_DDN,
    ST_ZZ,
    ST_RHS,
    ST_SIG,
    ST_FIN
  } state_t;

endpackage

@@ rtl/running_mean_variance_outlier.sv @@
// channel  | handshake            | payload
// request  | req_valid/req_ready  | action, sample
// response | rsp_valid/rsp_ready  | sample_count .. is_outlier
// config   | cfg_we               | cfg_addr, cfg_data
// one request at a time through a shared bit-serial unit (multiply, divide, square root)
// add: three 64-step divides, a 32-step root and six 33-step multiplies
// clear or check: two divides, the root and five multiplies, fewer divides while the count is below two
// rst is synchronous; statistics clear, thresholds take their defaults
// a waiting response stalls only the final load; once loaded, the next request is taken while it waits
module running_mean_variance_outlier (
  input  logic        clk,
  input  logic        rst,
  input  logic        req_valid,
  output logic        req_ready,
  input  logic [1:0]  action,
  input  logic [31:0] sample,
  output logic        rsp_valid,
  input  logic        rsp_ready,
  output logic [31:0] sample_count,
  output logic [31:0] mean_value,
  output logic [63:0] sample_variance,
  output logic [63:0] population_variance,
  output logic [31:0] std_deviation,
  output logic        mean_differs,
  output logic        is_outlier,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_addr,
  input  logic [31:0] cfg_data
);
  import rmv_pkg::*;

  state_t                state;
  state_t                state_next;
  logic                  issued;
  alu_cmd_t              alu_cmd;
  alu_stat_t             alu_st;
  logic [OPA_W-1:0]      alu_a;
  logic [OPB_W-1:0]      alu_b;
  logic [RES_W-1:0]      alu_res;

  logic [SAMPLE_W-1:0]   ref_mean;
  logic [THR_W-1:0]      z_thr;
  logic [THR_W-1:0]      sigma_thr;
  logic [COUNT_W-1:0]    min_samples;

  logic [COUNT_W-1:0]    count;
  logic [SAMPLE_W-1:0]   mean;
  logic [SUM_W-1:0]      ssd;

  logic [1:0]            act;
  logic [SAMPLE_W-1:0]   x;
  logic [SAMPLE_W:0]     d1;
  logic                  d1_neg;
  logic                  d1_zero;
  logic [SUM_W-1:0]      svar;
  logic [SUM_W-1:0]      pvar;
  logic [31:0]           sd;
  logic [63:0]           dd;
  logic [95:0]           dn;
  logic [31:0]           zz;
  logic [95:0]           rhs;
  logic [47:0]           sigp;

  logic [SAMPLE_W:0]     delta;
  logic [SAMPLE_W:0]     dmag;
  logic [SAMPLE_W:0]     rdiff;
  logic [SAMPLE_W:0]     rmag;
  logic [SAMPLE_W+2:0]   nm;
  logic [SAMPLE_W-1:0]   nm_sat;
  logic [SUM_W:0]        ssd_add;
  logic                  same_sign;
  logic                  gate;
  logic                  differs_c;
  logic                  outlier_c;
  logic                  fin_load;

  rmv_alu u_alu (
    .clk  (clk),
    .rst  (rst),
    .cmd  (alu_cmd),
    .opa  (alu_a),
    .opb  (alu_b),
    .stat (alu_st),
    .res  (alu_res)
  );

  always_comb begin
    delta = {x[SAMPLE_W-1], x} - {mean[SAMPLE_W-1], mean};
    dmag  = delta[SAMPLE_W] ? ((SAMPLE_W+1)'(0) - delta) : delta;
    rdiff = {mean[SAMPLE_W-1], mean} - {ref_mean[SAMPLE_W-1], ref_mean};
    rmag  = rdiff[SAMPLE_W] ? ((SAMPLE_W+1)'(0) - rdiff) : rdiff;
    nm    = delta[SAMPLE_W]
          ? ({{3{mean[SAMPLE_W-1]}}, mean} - {2'b00, alu_res[SAMPLE_W:0]})
          : ({{3{mean[SAMPLE_W-1]}}, mean} + {2'b00, alu_res[SAMPLE_W:0]});
    if (nm[SAMPLE_W+2:SAMPLE_W-1] != {4{nm[SAMPLE_W+2]}}) begin
      nm_sat = {nm[SAMPLE_W+2], {(SAMPLE_W-1){~nm[SAMPLE_W+2]}}};
    end else begin
      nm_sat = nm[SAMPLE_W-1:0];
    end
    ssd_add   = {1'b0, ssd} + {1'b0, alu_res[SUM_W-1:0]};
    same_sign = (d1_neg == delta[SAMPLE_W]) || d1_zero || (delta == '0);
    gate      = count >= min_samples;
    differs_c = gate && ({dn, 16'd0} > {16'd0, rhs});
    outlier_c = gate && ({7'd0, dmag, 8'd0} > sigp);
    fin_load  = (state == ST_FIN) && (!rsp_valid || rsp_ready);
  end

  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: if (req_valid) state_next = ST_UPD;
      ST_UPD:  state_next = (act == ACT_ADD) ? ST_Q : ST_SVAR;
      ST_Q:    if (alu_st.done) state_next = ST_P;
      ST_P:    if (alu_st.done) state_next = ST_SVAR;
      ST_SVAR: if (count < COUNT_W'(2) || alu_st.done) state_next = ST_PVAR;
      ST_PVAR: if (count == '0 || alu_st.done) state_next = ST_SQRT;
      ST_SQRT: if (alu_st.done) state_next = ST_DD;
      ST_DD:   if (alu_st.done) state_next = ST_DDN;
      ST_DDN:  if (alu_st.done) state_next = ST_ZZ;
      ST_ZZ:   if (alu_st.done) state_next = ST_RHS;
      ST_RHS:  if (alu_st.done) state_next = ST_SIG;
      ST_SIG:  if (alu_st.done) state_next = ST_FIN;
      ST_FIN:  if (fin_load) state_next = ST_IDLE;
      default: state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    req_ready     = (state == ST_IDLE);
    alu_cmd.start = 1'b0;
    alu_cmd.op    = OP_MUL;
    alu_a         = '0;
    alu_b         = '0;
    unique case (state)
      ST_Q: begin
        alu_cmd.start = !issued;
        alu_cmd.op    = OP_DIV;
        alu_a         = {31'd0, dmag};
        alu_b         = {1'b0, count};
      end
      ST_P: begin
        alu_cmd.start = !issued;
        alu_a         = {31'd0, d1};
        alu_b         = dmag;
      end
      ST_SVAR: begin
        alu_cmd.start = !issued && (count >= COUNT_W'(2));
        alu_cmd.op    = OP_DIV;
        alu_a         = ssd;
        alu_b         = {1'b0, count - 1'b1};
      end
      ST_PVAR: begin
        alu_cmd.start = !issued && (count != '0);
        alu_cmd.op    = OP_DIV;
        alu_a         = ssd;
        alu_b         = {1'b0, count};
      end
      ST_SQRT: begin
        alu_cmd.start = !issued;
        alu_cmd.op    = OP_SQRT;
        alu_a         = svar;
      end
      ST_DD: begin
        alu_cmd.start = !issued;
        alu_a         = {31'd0, rmag};
        alu_b         = rmag;
      end
      ST_DDN: begin
        alu_cmd.start = !issued;
        alu_a         = dd;
        alu_b         = {1'b0, count};
      end
      ST_ZZ: begin
        alu_cmd.start = !issued;
        alu_a         = {48'd0, z_thr};
        alu_b         = {17'd0, z_thr};
      end
      ST_RHS: begin
        alu_cmd.start = !issued;
        alu_a         = svar;
        alu_b         = {1'b0, zz};
      end
      ST_SIG: begin
        alu_cmd.start = !issued;
        alu_a         = {32'd0, sd};
        alu_b         = {17'd0, sigma_thr};
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      issued    <= 1'b0;
      rsp_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (alu_cmd.start) begin
        issued <= 1'b1;
      end else if (alu_st.done) begin
        issued <= 1'b0;
      end
      if (fin_load) begin
        rsp_valid <= 1'b1;
      end else if (rsp_ready) begin
        rsp_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      ref_mean    <= '0;
      z_thr       <= THR_W'(512);
      sigma_thr   <= THR_W'(768);
      min_samples <= COUNT_W'(2);
    end else if (cfg_we) begin
      unique case (cfg_reg_t'(cfg_addr))
        REG_REFERENCE_MEAN:  ref_mean    <= cfg_data;
        REG_Z_THRESHOLD:     z_thr       <= cfg_data[THR_W-1:0];
        REG_SIGMA_THRESHOLD: sigma_thr   <= cfg_data[THR_W-1:0];
        REG_MIN_SAMPLES:     min_samples <= cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
      mean  <= '0;
      ssd   <= '0;
    end else begin
      unique case (state)
        ST_UPD: begin
          if (act == ACT_CLEAR) begin
            count <= '0;
            mean  <= '0;
            ssd   <= '0;
          end else if (act == ACT_ADD && count != '1) begin
            count <= count + 1'b1;
          end
        end
        ST_Q: if (alu_st.done) mean <= nm_sat;
        ST_P: begin
          if (alu_st.done) begin
            if (same_sign) begin
              ssd <= ssd_add[SUM_W] ? '1 : ssd_add[SUM_W-1:0];
            end else begin
              ssd <= (ssd < alu_res[SUM_W-1:0]) ? '0 : ssd - alu_res[SUM_W-1:0];
            end
          end
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (state == ST_IDLE && req_valid) begin
      act <= action;
      x   <= sample;
    end
    if (state == ST_Q && alu_st.done) begin
      d1      <= dmag;
      d1_neg  <= delta[SAMPLE_W];
      d1_zero <= (delta == '0);
    end
    if (state == ST_SVAR) begin
      if (count < COUNT_W'(2)) svar <= '0;
      else if (alu_st.done) svar <= alu_res[SUM_W-1:0];
    end
    if (state == ST_PVAR) begin
      if (count == '0) pvar <= '0;
      else if (alu_st.done) pvar <= alu_res[SUM_W-1:0];
    end
    if (alu_st.done) begin
      unique case (state)
        ST_SQRT: sd   <= alu_res[31:0];
        ST_DD:   dd   <= alu_res[63:0];
        ST_DDN:  dn   <= alu_res[95:0];
        ST_ZZ:   zz   <= alu_res[31:0];
        ST_RHS:  rhs  <= alu_res[95:0];
        ST_SIG:  sigp <= alu_res[47:0];
        default: ;
      endcase
    end
    if (fin_load) begin
      sample_count        <= count;
      mean_value          <= mean;
      sample_variance     <= svar;
      population_variance <= pvar;
      std_deviation       <= sd;
      mean_differs        <= differs_c;
      is_outlier          <= outlier_c;
    end
  end

`ifndef SYNTHESIS
  a_alu_free: assert property (@(posedge clk) disable iff (rst)
    alu_cmd.start |-> !alu_st.busy)
    else $error("serial unit started while busy");

  a_mean_hold: assert property (@(posedge clk) disable iff (rst)
    !(state == ST_Q || state == ST_UPD) |=> $stable(mean))
    else $error("mean changed outside its update");

  a_count_mono: assert property (@(posedge clk) disable iff (rst)
    !(state == ST_UPD && act == ACT_CLEAR) |=> count >= $past(count))
    else $error("count dropped without clear");

  a_svar_zero: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && (sample_count < 32'd2) |-> sample_variance == '0)
    else $error("sample variance nonzero below two samples");
`endif

endmodule

@@ rtl/rmv_alu.sv @@
module rmv_alu (
  input  logic                        clk,
  input  logic                        rst,
  input  rmv_pkg::alu_cmd_t           cmd,
  input  logic [rmv_pkg::OPA_W-1:0]   opa,
  input  logic [rmv_pkg::OPB_W-1:0]   opb,
  output rmv_pkg::alu_stat_t          stat,
  output logic [rmv_pkg::RES_W-1:0]   res
);
  import rmv_pkg::*;

  alu_op_t            op_r;
  logic [CNT_W-1:0]   cnt;
  logic               busy;
  logic               done;
  logic [OPA_W-1:0]   hi;
  logic [OPA_W-1:0]   lo;
  logic [OPA_W-1:0]   aux;
  logic [OPA_W-1:0]   hi_next;
  logic [OPA_W-1:0]   lo_next;
  logic [OPA_W-1:0]   aux_next;

  logic [OPA_W:0]     mul_sum;
  logic [32:0]        div_t;
  logic [32:0]        div_sub;
  logic               div_ge;
  logic [35:0]        sq_t;
  logic [35:0]        sq_trial;
  logic [35:0]        sq_sub;
  logic               sq_ge;

  always_comb begin
    mul_sum  = {1'b0, hi} + (lo[0] ? {1'b0, aux} : '0);
    div_t    = {hi[31:0], lo[OPA_W-1]};
    div_ge   = div_t >= {1'b0, aux[31:0]};
    div_sub  = div_t - {1'b0, aux[31:0]};
    sq_t     = {hi[33:0], lo[OPA_W-1:OPA_W-2]};
    sq_trial = {2'b00, aux[31:0], 2'b01};
    sq_ge    = sq_t >= sq_trial;
    sq_sub   = sq_t - sq_trial;
    hi_next  = hi;
    lo_next  = lo;
    aux_next = aux;
    unique case (op_r)
      OP_MUL: begin
        hi_next = mul_sum[OPA_W:1];
        lo_next = {lo[OPA_W-1:OPB_W], mul_sum[0], lo[OPB_W-1:1]};
      end
      OP_DIV: begin
        hi_next = {32'd0, (div_ge ? div_sub[31:0] : div_t[31:0])};
        lo_next = {lo[OPA_W-2:0], div_ge};
      end
      OP_SQRT: begin
        hi_next  = {30'd0, (sq_ge ? sq_sub[33:0] : sq_t[33:0])};
        lo_next  = {lo[OPA_W-3:0], 2'b00};
        aux_next = {32'd0, aux[30:0], sq_ge};
      end
      default: ;
    endcase
  end

  always_comb begin
    unique case (op_r)
      OP_MUL:  res = {hi, lo[OPB_W-1:0]};
      OP_DIV:  res = {{OPB_W{1'b0}}, lo};
      OP_SQRT: res = {{(RES_W-32){1'b0}}, aux[31:0]};
      default: res = '0;
    endcase
    stat.busy = busy;
    stat.done = done;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (cmd.start && !busy) begin
        busy <= 1'b1;
        unique case (cmd.op)
          OP_MUL:  cnt <= CNT_W'(MUL_STEPS);
          OP_DIV:  cnt <= CNT_W'(DIV_STEPS);
          OP_SQRT: cnt <= CNT_W'(SQRT_STEPS);
          default: cnt <= CNT_W'(1);
        endcase
      end else if (busy) begin
        cnt <= cnt - 1'b1;
        if (cnt == CNT_W'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.start && !busy) begin
      op_r <= cmd.op;
      hi   <= '0;
      unique case (cmd.op)
        OP_MUL: begin
          lo  <= {{(OPA_W-OPB_W){1'b0}}, opb};
          aux <= opa;
        end
        OP_DIV: begin
          lo  <= opa;
          aux <= {{(OPA_W-OPB_W){1'b0}}, opb};
        end
        default: begin
          lo  <= opa;
          aux <= '0;
        end
      endcase
    end else if (busy) begin
      hi  <= hi_next;
      lo  <= lo_next;
      aux <= aux_next;
    end
  end

endmodule

@@ dv/running_mean_variance_outlier_test.sv @@
module running_mean_variance_outlier_test;
  import rmv_pkg::*;

  localparam logic [1:0] ACT_SPARE = 2'd3;
  localparam int         LIMIT_CYCLES = 6000000;
  localparam int         PHASE_ITEMS = 255;

  typedef struct packed {
    logic [31:0] count;
    logic [31:0] mean;
    logic [63:0] svar;
    logic [63:0] pvar;
    logic [31:0] sd;
    logic        differs;
    logic        outlier;
  } stats_t;

  typedef struct packed {
    logic [1:0]  act;
    logic [31:0] smp;
    logic        typed;
    stats_t      want;
  } row_t;

  logic        clk;
  logic        rst;
  logic        req_valid;
  logic        req_ready;
  logic [1:0]  action;
  logic [31:0] sample;
  logic        rsp_valid;
  logic        rsp_ready;
  logic [31:0] sample_count;
  logic [31:0] mean_value;
  logic [63:0] sample_variance;
  logic [63:0] population_variance;
  logic [31:0] std_deviation;
  logic        mean_differs;
  logic        is_outlier;
  logic        cfg_we;
  logic [1:0]  cfg_addr;
  logic [31:0] cfg_data;

  // predictor state and register copies
  logic [31:0] n_added;
  longint      cur_mean;
  logic [63:0] sq_dev_sum;
  logic [31:0] ref_mean_r;
  logic [15:0] z_thr_r;
  logic [15:0] sig_thr_r;
  logic [31:0] min_n_r;

  stats_t      expected_stats[$];
  int          mismatches;
  int          cycles;
  int          burst_left;
  int          stall_mode;
  int          stall_left;
  longint      center;
  row_t        directed[$];

  running_mean_variance_outlier i_dut (
    .clk(clk), .rst(rst),
    .req_valid(req_valid), .req_ready(req_ready), .action(action), .sample(sample),
    .rsp_valid(rsp_valid), .rsp_ready(rsp_ready),
    .sample_count(sample_count), .mean_value(mean_value),
    .sample_variance(sample_variance), .population_variance(population_variance),
    .std_deviation(std_deviation), .mean_differs(mean_differs), .is_outlier(is_outlier),
    .cfg_we(cfg_we), .cfg_addr(cfg_addr), .cfg_data(cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  function automatic logic [63:0] magnitude(input longint v);
    return v < 0 ? 64'(-v) : 64'(v);
  endfunction

  function automatic logic [63:0] floor_sqrt(input logic [63:0] v);
    logic [63:0] r;
    logic [63:0] b;
    r = '0;
    b = 64'h4000_0000_0000_0000;
    while (b > v) b = b >> 2;
    while (b != 0) begin
      if (v >= r + b) begin
        v = v - (r + b);
        r = (r >> 1) + b;
      end else begin
        r = r >> 1;
      end
      b = b >> 2;
    end
    return r;
  endfunction

  function automatic stats_t welford_update(input logic [1:0] act, input logic [31:0] smp);
    stats_t      res;
    longint      x;
    longint      delta;
    longint      delta2;
    longint      nm;
    logic [63:0] q;
    logic [127:0] p;
    logic [127:0] acc;
    logic [63:0] sv;
    logic [127:0] lhs;
    logic [127:0] rhs;
    logic [63:0] d;
    logic [63:0] dev;
    x = longint'($signed(smp));
    if (act == ACT_CLEAR) begin
      n_added = '0;
      cur_mean = 0;
      sq_dev_sum = '0;
    end else if (act == ACT_ADD) begin
      if (n_added != 32'hFFFF_FFFF) n_added = n_added + 1;
      delta = x - cur_mean;
      q = magnitude(delta) / {32'b0, n_added};
      nm = delta < 0 ? cur_mean - longint'(q) : cur_mean + longint'(q);
      if (nm > 64'sd2147483647) nm = 64'sd2147483647;
      if (nm < -64'sd2147483648) nm = -64'sd2147483648;
      cur_mean = nm;
      delta2 = x - nm;
      p = 128'(magnitude(delta)) * 128'(magnitude(delta2));
      if ((delta < 0) == (delta2 < 0) || delta == 0 || delta2 == 0) begin
        acc = 128'(sq_dev_sum) + p;
        sq_dev_sum = acc > 128'(64'hFFFF_FFFF_FFFF_FFFF) ? 64'hFFFF_FFFF_FFFF_FFFF : acc[63:0];
      end else begin
        sq_dev_sum = 128'(sq_dev_sum) < p ? 64'd0 : sq_dev_sum - p[63:0];
      end
    end
    sv = n_added < 2 ? 64'd0 : sq_dev_sum / (64'(n_added) - 1);
    res.count = n_added;
    res.mean = cur_mean[31:0];
    res.svar = sv;
    res.pvar = n_added == 0 ? 64'd0 : sq_dev_sum / 64'(n_added);
    res.sd = floor_sqrt(sv);
    res.differs = 1'b0;
    res.outlier = 1'b0;
    if (n_added >= min_n_r) begin
      d = magnitude(cur_mean - longint'($signed(ref_mean_r)));
      dev = magnitude(x - cur_mean);
      lhs = ((128'(d * d)) * 128'(n_added)) << 16;
      rhs = 128'(sv) * 128'(32'(z_thr_r) * 32'(z_thr_r));
      res.differs = lhs > rhs;
      res.outlier = (dev << 8) > 64'(sig_thr_r) * 64'(res.sd);
    end
    return res;
  endfunction

  // prediction on accepted requests, checking on accepted results
  always @(posedge clk) begin
    stats_t got;
    stats_t want;
    cycles <= cycles + 1;
    if (cycles > LIMIT_CYCLES) begin
      $display("Some tests failed");
      $finish;
    end
    if (rst) begin
      n_added = '0;
      cur_mean = 0;
      sq_dev_sum = '0;
      ref_mean_r = '0;
      z_thr_r = 16'd512;
      sig_thr_r = 16'd768;
      min_n_r = 32'd2;
    end else begin
      if (rsp_valid && rsp_ready) begin
        got = '{sample_count, mean_value, sample_variance, population_variance,
                std_deviation, mean_differs, is_outlier};
        if (expected_stats.size() == 0) begin
          mismatches++;
          if (mismatches <= 10) $display("unexpected result %p", got);
        end else begin
          want = expected_stats.pop_front();
          if (got.count !== want.count || got.mean !== want.mean ||
              got.svar !== want.svar || got.pvar !== want.pvar || got.sd !== want.sd ||
              got.differs !== want.differs || got.outlier !== want.outlier) begin
            mismatches++;
            if (mismatches <= 10) $display("mismatch: expected %p actual %p", want, got);
          end
        end
      end
      if (req_valid && req_ready) begin
        want = welford_update(action, sample);
        if (directed.size() != 0 && directed[0].typed) want = directed[0].want;
        if (directed.size() != 0) void'(directed.pop_front());
        expected_stats.push_back(want);
      end
      if (cfg_we) begin
        case (cfg_reg_t'(cfg_addr))
          REG_REFERENCE_MEAN:  ref_mean_r = cfg_data;
          REG_Z_THRESHOLD:     z_thr_r = cfg_data[15:0];
          REG_SIGMA_THRESHOLD: sig_thr_r = cfg_data[15:0];
          REG_MIN_SAMPLES:     min_n_r = cfg_data;
        endcase
      end
    end
  end

  // response stall pattern
  always @(negedge clk) begin
    if (stall_left == 0) begin
      stall_mode <= $urandom_range(0, 3);
      stall_left <= $urandom_range(20, 400);
    end else begin
      stall_left <= stall_left - 1;
    end
    case (stall_mode)
      0:       rsp_ready <= 1'b1;
      1:       rsp_ready <= $urandom_range(0, 1);
      2:       rsp_ready <= $urandom_range(0, 9) == 0;
      default: rsp_ready <= $urandom_range(0, 3) != 0;
    endcase
  end

  task automatic send_request(input logic [1:0] act, input logic [31:0] smp);
    int gap;
    if (burst_left == 0) begin
      gap = $urandom_range(0, 3) == 0 ? 0 : $urandom_range(1, 40);
      burst_left = $urandom_range(1, 8);
      req_valid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    burst_left--;
    req_valid = 1'b1;
    action = act;
    sample = smp;
    do @(posedge clk); while (!req_ready);
    @(negedge clk);
    req_valid = 1'b0;
  endtask

  task automatic write_reg(input cfg_reg_t idx, input logic [31:0] val);
    cfg_we = 1'b1;
    cfg_addr = idx;
    cfg_data = val;
    @(negedge clk);
    cfg_we = 1'b0;
  endtask

  task automatic drain;
    while (expected_stats.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    @(negedge clk);
  endtask

  function automatic logic [31:0] random_sample;
    case ($urandom_range(0, 9))
      0:       return $urandom;
      1:       return $urandom_range(0, 1) ? 32'h7FFF_FFFF : 32'h8000_0000;
      2:       return 32'($signed($urandom_range(0, 2000)) - 1000);
      default: return 32'(center + longint'($urandom_range(0, 32'h0008_0000)) - 32'h0004_0000);
    endcase
  endfunction

  function automatic logic [1:0] random_action;
    int r;
    r = $urandom_range(0, 99);
    if (r < 2) return ACT_CLEAR;
    if (r < 4) return ACT_SPARE;
    if (r < 28) return ACT_CHECK;
    return ACT_ADD;
  endfunction

  initial begin
    row_t r;
    row_t rows[$];
    rst = 1'b1;
    req_valid = 1'b0;
    action = ACT_CLEAR;
    sample = '0;
    rsp_ready = 1'b0;
    cfg_we = 1'b0;
    cfg_addr = REG_REFERENCE_MEAN;
    cfg_data = '0;
    mismatches = 0;
    cycles = 0;
    burst_left = 0;
    stall_mode = 0;
    stall_left = 0;
    center = 0;
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    directed = '{
      '{ACT_CHECK, 32'h7FFF_FFFF, 1'b1, '0},
      '{ACT_CLEAR, 32'h8000_0000, 1'b1, '0},
      '{ACT_ADD,   32'h7FFF_FFFF, 1'b0, '0},
      '{ACT_ADD,   32'h8000_0000, 1'b0, '0},
      '{ACT_CHECK, 32'h8000_0000, 1'b0, '0},
      '{ACT_ADD,   32'h0000_0000, 1'b0, '0},
      '{ACT_SPARE, 32'hFFFF_FFFF, 1'b0, '0},
      '{ACT_ADD,   32'h8000_0000, 1'b0, '0},
      '{ACT_CLEAR, 32'h0000_0000, 1'b1, '0},
      '{ACT_ADD,   32'h0001_0000, 1'b0, '0},
      '{ACT_CHECK, 32'h0002_0000, 1'b0, '0},
      '{ACT_ADD,   32'h0001_0000, 1'b0, '0},
      '{ACT_ADD,   32'h0001_0000, 1'b0, '0},
      '{ACT_CHECK, 32'h7FFF_FFFF, 1'b0, '0},
      '{ACT_CHECK, 32'h0001_0000, 1'b0, '0},
      '{ACT_ADD,   32'h0003_0000, 1'b0, '0},
      '{ACT_ADD,   32'hFFFF_FFFF, 1'b0, '0},
      '{ACT_ADD,   32'h0000_0001, 1'b0, '0},
      '{ACT_CHECK, 32'h0010_0000, 1'b0, '0},
      '{ACT_ADD,   32'h5555_5555, 1'b0, '0},
      '{ACT_ADD,   32'hAAAA_AAAA, 1'b0, '0},
      '{ACT_CHECK, 32'h0000_0000, 1'b0, '0}
    };
    // the predictor consumes directed as requests are accepted
    rows = directed;
    foreach (rows[k]) begin
      r = rows[k];
      send_request(r.act, r.smp);
    end
    drain();

    for (int ph = 0; ph < 6; ph++) begin
      case (ph)
        0: begin
          write_reg(REG_REFERENCE_MEAN, 32'h0);
          write_reg(REG_Z_THRESHOLD, 32'd512);
          write_reg(REG_SIGMA_THRESHOLD, 32'd768);
          write_reg(REG_MIN_SAMPLES, 32'd2);
        end
        1: begin
          write_reg(REG_REFERENCE_MEAN, 32'h8000_0000);
          write_reg(REG_Z_THRESHOLD, 32'd0);
          write_reg(REG_SIGMA_THRESHOLD, 32'd0);
          write_reg(REG_MIN_SAMPLES, 32'd0);
        end
        2: begin
          write_reg(REG_REFERENCE_MEAN, 32'h7FFF_FFFF);
          write_reg(REG_Z_THRESHOLD, 32'hFFFF_FFFF);
          write_reg(REG_SIGMA_THRESHOLD, 32'hFFFF_FFFF);
          write_reg(REG_MIN_SAMPLES, 32'hFFFF_FFFF);
        end
        3: begin
          write_reg(REG_REFERENCE_MEAN, 32'h0001_0000);
          write_reg(REG_Z_THRESHOLD, 32'd256);
          write_reg(REG_SIGMA_THRESHOLD, 32'd512);
          write_reg(REG_MIN_SAMPLES, 32'd1);
        end
        default: begin
          write_reg(REG_REFERENCE_MEAN, $urandom);
          write_reg(REG_Z_THRESHOLD, $urandom_range(0, 2000));
          write_reg(REG_SIGMA_THRESHOLD, $urandom_range(0, 2000));
          write_reg(REG_MIN_SAMPLES, $urandom_range(0, 10));
        end
      endcase
      center = longint'($signed($urandom));
      if (ph == 3) begin
        write_reg(REG_REFERENCE_MEAN, 32'(center));
      end
      for (int i = 0; i < PHASE_ITEMS; i++) begin
        if (i % 60 == 59) center = longint'($signed($urandom)) >>> $urandom_range(0, 12);
        send_request(random_action(), random_sample());
      end
      drain();
    end

    while (expected_stats.size() != 0) @(posedge clk);
    repeat (600) @(posedge clk);
    if (mismatches == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
